/* hw/rtl/wrg_pkg.sv */
// ----------------------------------------------------------------------------
// wrg_pkg
// Shared types and constants for the WELL512a random word generator.
// ----------------------------------------------------------------------------
package wrg_pkg;

   localparam int POOL_DEPTH  = 16;
   localparam int IDX_W       = 4;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [31:0]      TEMPER_MASK = 32'hDA442D24;
   localparam logic [IDX_W-1:0] OFF_A       = 4'd13;
   localparam logic [IDX_W-1:0] OFF_C       = 4'd9;
   localparam logic [IDX_W-1:0] OFF_PREV    = 4'd15;

   typedef enum logic [1:0] {
      OP_RAW    = 2'd0,
      OP_URANGE = 2'd1,
      OP_SRANGE = 2'd2,
      OP_SEED   = 2'd3
   } op_type;

   // classified request as it sits in the queue
   typedef struct packed {
      op_type      op;
      logic [31:0] low_bound;
      logic [31:0] divisor;
      logic        zero_width;
      logic [31:0] seed_value;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

endpackage

/* hw/rtl/wrg_if.sv */
// ----------------------------------------------------------------------------
// wrg_req_if / wrg_rsp_if
// Valid/ready channels for requests and result words.
// ----------------------------------------------------------------------------
interface wrg_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [31:0] low_bound;
   logic [31:0] high_bound;
   logic [31:0] seed_value;

   modport source (output valid, req_type, low_bound, high_bound, seed_value,
                   input ready);
   modport sink   (input valid, req_type, low_bound, high_bound, seed_value,
                   output ready);
endinterface

interface wrg_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] value;
   logic        range_error;

   modport source (output valid, value, range_error, input ready);
   modport sink   (input valid, value, range_error, output ready);
endinterface

/* hw/rtl/well512_random_generator_core.sv */
// ----------------------------------------------------------------------------
// well512_random_generator_core
// WELL512a random word generator with range mapping and reseeding.
// ----------------------------------------------------------------------------
// Each request gives one result word. One generator step runs through the
// states ST_G0 to ST_G3, paced by the single write port of the 16-word pool
// (two reads, then two writes). A raw word or a zero-width range goes from
// the queue to the result register after one step; a range request adds a
// serial remainder (ST_DIV) and a fix-up state (ST_FIN); a reseed runs 16
// rounds of one seed write and one step. The back end works on one
// request at a time while the front keeps queuing, and a finished result
// waits in the output register without blocking the next request's work.
// ----------------------------------------------------------------------------
module well512_random_generator_core import wrg_pkg::*; #(
   parameter int QueueDepth = QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   wrg_req_if.sink    req_chan,
   wrg_rsp_if.source  rsp_chan
);

   q_stat_type q_stat;
   logic       push;
   logic       pop;
   cmd_type    push_cmd;
   cmd_type    pop_cmd;

   wrg_front u_front (
      .req_chan (req_chan),
      .q_stat   (q_stat),
      .push     (push),
      .push_cmd (push_cmd)
   );

   wrg_cmd_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .pop_cmd  (pop_cmd),
      .q_stat   (q_stat)
   );

   wrg_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_stat   (q_stat),
      .pop_cmd  (pop_cmd),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

/* hw/rtl/wrg_front.sv */
// ----------------------------------------------------------------------------
// wrg_front
// Accepts request words, works out the range width and divisor magnitude.
// ----------------------------------------------------------------------------
module wrg_front import wrg_pkg::*; (
   wrg_req_if.sink    req_chan,
   input  q_stat_type q_stat,
   output logic       push,
   output cmd_type    push_cmd
);

   op_type      op;
   logic [31:0] width;

   always_comb begin
      op    = op_type'(req_chan.req_type);
      width = req_chan.high_bound + 32'd1 - req_chan.low_bound;

      push_cmd.op         = op;
      push_cmd.low_bound  = req_chan.low_bound;
      push_cmd.zero_width = (width == 32'd0);
      push_cmd.seed_value = req_chan.seed_value;
      // signed range divides by the magnitude of the width
      if (op == OP_SRANGE && width[31]) begin
         push_cmd.divisor = 32'd0 - width;
      end else begin
         push_cmd.divisor = width;
      end
   end

   assign req_chan.ready = !q_stat.full;
   assign push           = req_chan.valid && !q_stat.full;

endmodule

/* hw/rtl/wrg_cmd_queue.sv */
// ----------------------------------------------------------------------------
// wrg_cmd_queue
// Small FIFO of classified requests between front and back.
// ----------------------------------------------------------------------------
module wrg_cmd_queue import wrg_pkg::*; #(
   parameter int Depth = QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  cmd_type    push_cmd,
   input  logic       pop,
   output cmd_type    pop_cmd,
   output q_stat_type q_stat
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

   cmd_type         entries_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign pop_cmd      = entries_ff[rd_ptr_ff];
   assign q_stat.full  = (count_ff == FullCnt);
   assign q_stat.empty = (count_ff == '0);

endmodule

/* hw/rtl/wrg_back.sv */
// ----------------------------------------------------------------------------
// wrg_back
// Generator pool, step sequencer, serial remainder and result register.
// ----------------------------------------------------------------------------
module wrg_back import wrg_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  q_stat_type q_stat,
   input  cmd_type    pop_cmd,
   output logic       pop,
   wrg_rsp_if.source  rsp_chan
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_SEED, ST_G0, ST_G1, ST_G2, ST_G3, ST_DIV, ST_FIN, ST_DONE
   } state_type;

   localparam logic [IDX_W-1:0] LastEntry = IDX_W'(POOL_DEPTH - 1);

   // pool memory, two registered read ports, one write port
   logic [31:0]      pool_mem [POOL_DEPTH];
   logic             pool_vld_ff [POOL_DEPTH];
   logic [IDX_W-1:0] ra_a, ra_b, wa;
   logic             we;
   logic [31:0]      wd;
   logic [31:0]      rda_ff, rdb_ff;
   logic             rda_vld_ff, rdb_vld_ff;
   logic [31:0]      rd_a, rd_b;

   state_type        state_ff, state_in;
   cmd_type          cmd_ff, cmd_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] k_ff, k_in;
   logic [31:0]      b_ff, b_in;
   logic [31:0]      fin_ff, fin_in;
   logic [31:0]      num_ff, num_in;
   logic [31:0]      rem_ff, rem_in;
   logic [4:0]       cnt_ff, cnt_in;
   logic             neg_ff, neg_in;
   logic [31:0]      res_ff, res_in;
   logic             err_ff, err_in;
   logic             out_valid_ff, out_valid_in;
   logic [31:0]      out_value_ff, out_value_in;
   logic             out_err_ff, out_err_in;

   logic [31:0]      c_mix, v_new, d_tmp;
   logic [32:0]      trial, trial_sub;
   logic             trial_ge;
   logic             load_out;

   assign rd_a = rda_vld_ff ? rda_ff : 32'd0;
   assign rd_b = rdb_vld_ff ? rdb_ff : 32'd0;

   always_ff @(posedge clock) begin
      if (we) begin
         pool_mem[wa] <= wd;
      end
      rda_ff <= pool_mem[ra_a];
      rdb_ff <= pool_mem[ra_b];
   end

   // entries never written read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < POOL_DEPTH; i++) begin
            pool_vld_ff[i] <= 1'b0;
         end
         rda_vld_ff <= 1'b0;
         rdb_vld_ff <= 1'b0;
      end else begin
         if (we) begin
            pool_vld_ff[wa] <= 1'b1;
         end
         rda_vld_ff <= pool_vld_ff[ra_a];
         rdb_vld_ff <= pool_vld_ff[ra_b];
      end
   end

   // recurrence mix for the second half of a step, and the remainder trial
   always_comb begin
      c_mix = rd_a ^ (rd_a >> 11);
      v_new = b_ff ^ c_mix;
      d_tmp = v_new ^ ((v_new << 5) & TEMPER_MASK);
      trial     = {rem_ff, num_ff[31]};
      trial_sub = trial - {1'b0, cmd_ff.divisor};
      trial_ge  = (trial >= {1'b0, cmd_ff.divisor});
   end

   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      idx_in   = idx_ff;
      k_in     = k_ff;
      b_in     = b_ff;
      fin_in   = fin_ff;
      num_in   = num_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      neg_in   = neg_ff;
      res_in   = res_ff;
      err_in   = err_ff;
      pop      = 1'b0;
      we       = 1'b0;
      wa       = idx_ff;
      wd       = v_new;
      ra_a     = idx_ff;
      ra_b     = idx_ff + OFF_A;
      load_out = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (!q_stat.empty) begin
               pop      = 1'b1;
               cmd_in   = pop_cmd;
               k_in     = '0;
               state_in = (pop_cmd.op == OP_SEED) ? ST_SEED : ST_G0;
            end
         end
         ST_SEED: begin
            we       = 1'b1;
            wa       = k_ff;
            wd       = cmd_ff.seed_value + 32'(k_ff);
            state_in = ST_G0;
         end
         ST_G0: begin
            state_in = ST_G1;
         end
         ST_G1: begin
            b_in     = rd_a ^ rd_b ^ (rd_a << 16) ^ (rd_b << 15);
            ra_a     = idx_ff + OFF_C;
            ra_b     = idx_ff + OFF_PREV;
            state_in = ST_G2;
         end
         ST_G2: begin
            we       = 1'b1;
            wa       = idx_ff;
            wd       = v_new;
            fin_in   = rd_b ^ b_ff ^ d_tmp ^ (rd_b << 2) ^ (b_ff << 18) ^ (c_mix << 28);
            state_in = ST_G3;
         end
         ST_G3: begin
            we     = 1'b1;
            wa     = idx_ff + OFF_PREV;
            wd     = fin_ff;
            idx_in = idx_ff + OFF_PREV;
            err_in = 1'b0;
            if (cmd_ff.op == OP_SEED) begin
               if (k_ff == LastEntry) begin
                  idx_in   = '0;
                  res_in   = 32'd0;
                  state_in = ST_DONE;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = ST_SEED;
               end
            end else if (cmd_ff.op == OP_RAW) begin
               res_in   = fin_ff;
               state_in = ST_DONE;
            end else if (cmd_ff.zero_width) begin
               res_in   = fin_ff + cmd_ff.low_bound;
               err_in   = 1'b1;
               state_in = ST_DONE;
            end else begin
               neg_in   = (cmd_ff.op == OP_SRANGE) && fin_ff[31];
               num_in   = ((cmd_ff.op == OP_SRANGE) && fin_ff[31]) ? 32'd0 - fin_ff
                                                                    : fin_ff;
               rem_in   = 32'd0;
               cnt_in   = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            // restoring remainder, one dividend bit a cycle
            rem_in = trial_ge ? trial_sub[31:0] : trial[31:0];
            num_in = {num_ff[30:0], 1'b0};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 5'd31) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            res_in   = cmd_ff.low_bound + (neg_ff ? 32'd0 - rem_ff : rem_ff);
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!out_valid_ff || rsp_chan.ready) begin
               load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      out_valid_in = load_out || (out_valid_ff && !rsp_chan.ready);
      out_value_in = load_out ? res_ff : out_value_ff;
      out_err_in   = load_out ? err_ff : out_err_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
      cmd_ff       <= cmd_in;
      k_ff         <= k_in;
      b_ff         <= b_in;
      fin_ff       <= fin_in;
      num_ff       <= num_in;
      rem_ff       <= rem_in;
      cnt_ff       <= cnt_in;
      neg_ff       <= neg_in;
      res_ff       <= res_in;
      err_ff       <= err_in;
      out_value_ff <= out_value_in;
      out_err_ff   <= out_err_in;
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.value       = out_value_ff;
   assign rsp_chan.range_error = out_err_ff;

endmodule
